// File: src/hslrgb_pkg.sv
// Shared types, constants and helpers of the HSL to RGB conversion pipeline.
package hslrgb_pkg;

   localparam int FRAC_BITS = 16;

   // Value widths derived from the internal fraction width
   localparam int ONE_W = FRAC_BITS + 1;
   localparam int LVL_W = FRAC_BITS + 2;
   localparam int Q_W   = 12;
   localparam int CQ_W  = ONE_W + Q_W;
   localparam int N_W   = CQ_W - 8;

   // floor(n / 15) by reciprocal: estimate is exact or one low
   localparam int RCP_K = N_W;
   localparam int RCP_W = RCP_K - 3;
   localparam longint unsigned RCP_M_L = (64'd1 << RCP_K) / 15;
   localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_M_L);
   localparam logic [N_W-1:0] DIV_REST = N_W'(15);

   localparam int UP_SH = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
   localparam int DN_SH = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;

   localparam logic [15:0] HUE_FULL  = 16'd23040;
   localparam logic [15:0] HUE_TWICE = 16'd46080;
   localparam logic [14:0] HUE_SEXT  = 15'd3840;
   localparam logic [16:0] Q16_ONE   = 17'h10000;

   typedef enum logic [2:0] {
      SEXT_RED_YEL = 3'd0,
      SEXT_YEL_GRN = 3'd1,
      SEXT_GRN_CYN = 3'd2,
      SEXT_CYN_BLU = 3'd3,
      SEXT_BLU_MAG = 3'd4,
      SEXT_MAG_RED = 3'd5
   } sext_type;

   typedef struct packed {
      logic [15:0] hue_angle;
      logic [16:0] sat_level;
      logic [16:0] light_level;
      logic [7:0]  alpha_in;
   } hsl_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } hsl_rsp_type;

   // Front end result: sextant, position, doubled lightness, s * (1 - |2l - 1|)
   typedef struct packed {
      sext_type             sext;
      logic [Q_W-1:0]       q;
      logic [LVL_W-1:0]     two_l;
      logic [2*ONE_W-1:0]   sc;
      logic [7:0]           alpha;
   } st2_type;

   typedef struct packed {
      logic    valid;
      st2_type data;
   } pipe2_type;

   // Chroma and hue ramp term, ready for level forming
   typedef struct packed {
      sext_type         sext;
      logic [LVL_W-1:0] two_l;
      logic [ONE_W-1:0] chroma;
      logic [ONE_W-1:0] x;
      logic [7:0]       alpha;
   } st5_type;

   typedef struct packed {
      logic    valid;
      st5_type data;
   } pipe5_type;

   // Q1.16 to internal fraction width
   function automatic logic [ONE_W-1:0] to_internal(input logic [16:0] v);
      logic [ONE_W+15:0] w;
      w = (ONE_W + 16)'(v);
      w = (w << UP_SH) >> DN_SH;
      return w[ONE_W-1:0];
   endfunction

endpackage

// File: src/hsl_to_rgb_convert_unit.sv
// Top level of the HSL to RGB pixel converter.
// One pixel is taken in every clock: busy stays low, so each cycle with start
// high is a transfer. The result leaves 7 cycles later on rsp_data with a
// one-cycle rsp_strobe, in input order, and must be captured in that cycle.
// The seven register stages are hue wrap and clamp, sextant split with the
// saturation product, the hue ramp product, the reciprocal product that
// divides it by the sextant width, the remainder fix, channel selection, and
// scaling to 8 bits; each multiplier sits in a stage of its own.
module hsl_to_rgb_convert_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  hslrgb_pkg::hsl_req_type req_data,
   output logic                    rsp_strobe,
   output hslrgb_pkg::hsl_rsp_type rsp_data
);
   import hslrgb_pkg::*;

   logic      in_xfer;
   pipe2_type st2;
   pipe5_type st5;

   assign busy    = 1'b0;
   assign in_xfer = start & ~busy;

   hslrgb_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_xfer (in_xfer),
      .req     (req_data),
      .st2     (st2)
   );

   hslrgb_xcalc u_xcalc (
      .clock (clock),
      .reset (reset),
      .st2   (st2),
      .st5   (st5)
   );

   hslrgb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .st5        (st5),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_xfer |-> ##7 rsp_strobe)
      else $error("transfer did not produce a result after 7 cycles");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !in_xfer |-> ##7 !rsp_strobe)
      else $error("result without a matching transfer");

   a_alpha_pass: assert property (@(posedge clock) disable iff (reset)
      in_xfer |-> ##7 (rsp_data.alpha_out == $past(req_data.alpha_in, 7)))
      else $error("alpha not carried through");

endmodule

// File: src/hslrgb_front.sv
// Front stages: hue wrap and input clamp, then sextant split and saturation product.
module hslrgb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_xfer,
   input  hslrgb_pkg::hsl_req_type req,
   output hslrgb_pkg::pipe2_type   st2
);
   import hslrgb_pkg::*;

   typedef struct packed {
      logic [14:0]      hue;
      logic [ONE_W-1:0] s;
      logic [ONE_W-1:0] l;
      logic [7:0]       alpha;
   } st1_type;

   logic    v1_ff, v2_ff;
   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;

   logic [15:0] hue_w;
   logic [16:0] s_cl, l_cl;

   always_comb begin
      if (req.hue_angle >= HUE_TWICE) begin
         hue_w = req.hue_angle - HUE_TWICE;
      end else if (req.hue_angle >= HUE_FULL) begin
         hue_w = req.hue_angle - HUE_FULL;
      end else begin
         hue_w = req.hue_angle;
      end
      s_cl = (req.sat_level > Q16_ONE) ? Q16_ONE : req.sat_level;
      l_cl = (req.light_level > Q16_ONE) ? Q16_ONE : req.light_level;
      st1_in.hue   = hue_w[14:0];
      st1_in.s     = to_internal(s_cl);
      st1_in.l     = to_internal(l_cl);
      st1_in.alpha = req.alpha_in;
   end

   logic [2:0]       cnt;
   logic [14:0]      base;
   logic [Q_W-1:0]   pos;
   logic [LVL_W-1:0] one_l, two_l, dev;
   logic [ONE_W-1:0] om;

   always_comb begin
      cnt = 3'd0;
      for (int i = 1; i < 6; i++) begin
         if (st1_ff.hue >= 15'(i) * HUE_SEXT) begin
            cnt = cnt + 3'd1;
         end
      end
      base = 15'(cnt) * HUE_SEXT;
      pos  = Q_W'(st1_ff.hue - base);

      one_l = LVL_W'(1) << FRAC_BITS;
      two_l = {st1_ff.l, 1'b0};
      dev   = (two_l >= one_l) ? (two_l - one_l) : (one_l - two_l);
      om    = (dev <= one_l) ? ONE_W'(one_l - dev) : '0;

      st2_in.sext  = sext_type'(cnt);
      // falling half of the ramp in odd sextants
      st2_in.q     = cnt[0] ? (Q_W'(HUE_SEXT) - pos) : pos;
      st2_in.two_l = two_l;
      st2_in.sc    = (2*ONE_W)'(st1_ff.s) * (2*ONE_W)'(om);
      st2_in.alpha = st1_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_xfer;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff <= st1_in;
      st2_ff <= st2_in;
   end

   assign st2.valid = v2_ff;
   assign st2.data  = st2_ff;

endmodule

// File: src/hslrgb_xcalc.sv
// Middle stages: chroma, hue ramp product and its division by the sextant width.
module hslrgb_xcalc (
   input  logic                  clock,
   input  logic                  reset,
   input  hslrgb_pkg::pipe2_type st2,
   output hslrgb_pkg::pipe5_type st5
);
   import hslrgb_pkg::*;

   typedef struct packed {
      sext_type         sext;
      logic [LVL_W-1:0] two_l;
      logic [ONE_W-1:0] chroma;
      logic [CQ_W-1:0]  cq;
      logic [7:0]       alpha;
   } st3_type;

   typedef struct packed {
      sext_type         sext;
      logic [LVL_W-1:0] two_l;
      logic [ONE_W-1:0] chroma;
      logic [N_W-1:0]   n;
      logic [ONE_W-1:0] est;
      logic [7:0]       alpha;
   } st4_type;

   logic    v3_ff, v4_ff, v5_ff;
   st3_type st3_ff, st3_in;
   st4_type st4_ff, st4_in;
   st5_type st5_ff, st5_in;

   logic [ONE_W-1:0]     chroma;
   logic [N_W-1:0]       n;
   logic [N_W+RCP_W-1:0] rprod;
   logic [N_W-1:0]       times15, rem;

   always_comb begin
      chroma        = st2.data.sc[FRAC_BITS +: ONE_W];
      st3_in.sext   = st2.data.sext;
      st3_in.two_l  = st2.data.two_l;
      st3_in.chroma = chroma;
      st3_in.cq     = CQ_W'(chroma) * CQ_W'(st2.data.q);
      st3_in.alpha  = st2.data.alpha;
   end

   // divide by 3840: drop 8 bits, then divide by 15 through the reciprocal
   always_comb begin
      n             = st3_ff.cq[CQ_W-1:8];
      rprod         = (N_W+RCP_W)'(n) * (N_W+RCP_W)'(RCP_M);
      st4_in.sext   = st3_ff.sext;
      st4_in.two_l  = st3_ff.two_l;
      st4_in.chroma = st3_ff.chroma;
      st4_in.n      = n;
      st4_in.est    = rprod[RCP_K +: ONE_W];
      st4_in.alpha  = st3_ff.alpha;
   end

   // estimate may be one low: fix it from the remainder
   always_comb begin
      times15       = N_W'({st4_ff.est, 4'b0000}) - N_W'(st4_ff.est);
      rem           = st4_ff.n - times15;
      st5_in.sext   = st4_ff.sext;
      st5_in.two_l  = st4_ff.two_l;
      st5_in.chroma = st4_ff.chroma;
      st5_in.x      = st4_ff.est + ONE_W'(rem >= DIV_REST);
      st5_in.alpha  = st4_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= st2.valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      st3_ff <= st3_in;
      st4_ff <= st4_in;
      st5_ff <= st5_in;
   end

   assign st5.valid = v5_ff;
   assign st5.data  = st5_ff;

   a_x_le_chroma: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (st5_ff.x <= st5_ff.chroma))
      else $error("ramp term exceeds chroma");

   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (rem < (DIV_REST + DIV_REST)))
      else $error("reciprocal estimate off by more than one");

endmodule

// File: src/hslrgb_out.sv
// Back stages: channel levels by sextant, scaling to 8 bits and saturation.
module hslrgb_out (
   input  logic                    clock,
   input  logic                    reset,
   input  hslrgb_pkg::pipe5_type   st5,
   output logic                    rsp_strobe,
   output hslrgb_pkg::hsl_rsp_type rsp_data
);
   import hslrgb_pkg::*;

   typedef struct packed {
      logic [LVL_W-1:0] lvl_r;
      logic [LVL_W-1:0] lvl_g;
      logic [LVL_W-1:0] lvl_b;
      logic [7:0]       alpha;
   } st6_type;

   function automatic logic [7:0] chan_of(input logic [LVL_W-1:0] lvl);
      logic [LVL_W+7:0] w;
      logic [8:0]       v;
      w = {lvl, 8'h00} - (LVL_W + 8)'(lvl);
      v = w[LVL_W+7:FRAC_BITS+1];
      return (v > 9'd255) ? 8'hFF : v[7:0];
   endfunction

   logic        v6_ff, strobe_ff;
   st6_type     st6_ff, st6_in;
   hsl_rsp_type rsp_ff, rsp_in;

   logic [LVL_W-1:0] hi, lo, mid;

   always_comb begin
      hi  = st5.data.two_l + LVL_W'(st5.data.chroma);
      lo  = (st5.data.two_l >= LVL_W'(st5.data.chroma)) ?
            (st5.data.two_l - LVL_W'(st5.data.chroma)) : '0;
      mid = lo + LVL_W'({st5.data.x, 1'b0});
      st6_in.alpha = st5.data.alpha;
      case (st5.data.sext)
         SEXT_RED_YEL: begin
            st6_in.lvl_r = hi;  st6_in.lvl_g = mid; st6_in.lvl_b = lo;
         end
         SEXT_YEL_GRN: begin
            st6_in.lvl_r = mid; st6_in.lvl_g = hi;  st6_in.lvl_b = lo;
         end
         SEXT_GRN_CYN: begin
            st6_in.lvl_r = lo;  st6_in.lvl_g = hi;  st6_in.lvl_b = mid;
         end
         SEXT_CYN_BLU: begin
            st6_in.lvl_r = lo;  st6_in.lvl_g = mid; st6_in.lvl_b = hi;
         end
         SEXT_BLU_MAG: begin
            st6_in.lvl_r = mid; st6_in.lvl_g = lo;  st6_in.lvl_b = hi;
         end
         default: begin
            st6_in.lvl_r = hi;  st6_in.lvl_g = lo;  st6_in.lvl_b = mid;
         end
      endcase
   end

   always_comb begin
      rsp_in.red_out   = chan_of(st6_ff.lvl_r);
      rsp_in.green_out = chan_of(st6_ff.lvl_g);
      rsp_in.blue_out  = chan_of(st6_ff.lvl_b);
      rsp_in.alpha_out = st6_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v6_ff     <= st5.valid;
         strobe_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      st6_ff <= st6_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: tb/sv/tb_hsl_to_rgb_checker.sv
// Checker for the HSL to RGB converter: predicts each pixel and compares every result channel.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  hslrgb_pkg::hsl_req_type req_data,
   input  logic                    rsp_strobe,
   input  hslrgb_pkg::hsl_rsp_type rsp_data,
   input  logic                    final_check,
   output int unsigned             mismatch_count,
   output int unsigned             pending_count
);
   import hslrgb_pkg::*;

   hsl_rsp_type rgb_pending[$];
   hsl_rsp_type want;
   int unsigned mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   // 255 * level / 2^(FRAC_BITS+1), truncated, saturated to 8 bits
   function automatic logic [7:0] scale_level(input logic [63:0] level);
      logic [63:0] v;
      v = (64'd255 * level) >> (FRAC_BITS + 1);
      return (v > 64'd255) ? 8'd255 : v[7:0];
   endfunction

   function automatic hsl_rsp_type hsl_pixel_to_rgb(input hsl_req_type px);
      logic [63:0] one, hue, s16, l16, s, l, two_l, dev, om, chroma;
      logic [63:0] pos, ramp, x, hi, lo, mid, r, g, b;
      sext_type    sext;
      hsl_rsp_type rgb;
      one = 64'd1 << FRAC_BITS;
      hue = 64'(px.hue_angle) % 64'(HUE_FULL);
      s16 = (px.sat_level > Q16_ONE) ? 64'(Q16_ONE) : 64'(px.sat_level);
      l16 = (px.light_level > Q16_ONE) ? 64'(Q16_ONE) : 64'(px.light_level);
      s = (s16 << UP_SH) >> DN_SH;
      l = (l16 << UP_SH) >> DN_SH;

      two_l = 2 * l;
      dev = (two_l >= one) ? two_l - one : one - two_l;
      om = (dev <= one) ? one - dev : 64'd0;
      chroma = (s * om) >> FRAC_BITS;

      sext = sext_type'(3'(hue / 64'(HUE_SEXT)));
      pos = hue % 64'(HUE_SEXT);
      // falling ramp in odd sextants
      ramp = sext[0] ? 64'(HUE_SEXT) - pos : pos;
      x = (chroma * ramp) / 64'(HUE_SEXT);

      hi = two_l + chroma;
      lo = (two_l >= chroma) ? two_l - chroma : 64'd0;
      mid = lo + 2 * x;

      case (sext)
         SEXT_RED_YEL: begin r = hi;  g = mid; b = lo;  end
         SEXT_YEL_GRN: begin r = mid; g = hi;  b = lo;  end
         SEXT_GRN_CYN: begin r = lo;  g = hi;  b = mid; end
         SEXT_CYN_BLU: begin r = lo;  g = mid; b = hi;  end
         SEXT_BLU_MAG: begin r = mid; g = lo;  b = hi;  end
         default:      begin r = hi;  g = lo;  b = mid; end
      endcase

      rgb.red_out   = scale_level(r);
      rgb.green_out = scale_level(g);
      rgb.blue_out  = scale_level(b);
      rgb.alpha_out = px.alpha_in;
      return rgb;
   endfunction

   task automatic check_channel(input string name, input logic [7:0] got,
                                input logic [7:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s got %0d, predicted %0d", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            rgb_pending.push_back(hsl_pixel_to_rgb(req_data));
         if (rsp_strobe) begin
            if (rgb_pending.size() == 0) begin
               report_mismatch("result transfer with no pixel outstanding");
            end else begin
               want = rgb_pending.pop_front();
               check_channel("red_out",   rsp_data.red_out,   want.red_out);
               check_channel("green_out", rsp_data.green_out, want.green_out);
               check_channel("blue_out",  rsp_data.blue_out,  want.blue_out);
               check_channel("alpha_out", rsp_data.alpha_out, want.alpha_out);
            end
         end
         if (final_check && rgb_pending.size() != 0)
            report_mismatch($sformatf("%0d pixels never came out", rgb_pending.size()));
      end
      pending_count <= rgb_pending.size();
   end

endmodule

// File: tb/sv/tb_hsl_to_rgb_convert_unit.sv
// Testbench top for the HSL to RGB converter: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_convert_unit;
   import hslrgb_pkg::*;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   hsl_req_type req_data = '0;
   logic        rsp_strobe;
   hsl_rsp_type rsp_data;
   logic        final_check = 1'b0;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned sender_idle_pct;

   hsl_to_rgb_convert_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   tb_hsl_to_rgb_checker pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .final_check    (final_check),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   function automatic hsl_req_type make_pixel(input int unsigned h, input int unsigned s,
                                              input int unsigned l, input int unsigned a);
      hsl_req_type px;
      px.hue_angle   = 16'(h);
      px.sat_level   = 17'(s);
      px.light_level = 17'(l);
      px.alpha_in    = 8'(a);
      return px;
   endfunction

   // saturation or lightness: mostly in range, some at the ends and above 1.0
   function automatic int unsigned random_level();
      case ($urandom_range(9))
         0: return 0;
         1: return 65536;
         2: return $urandom_range(131071, 65537);
         3: return $urandom_range(65536, 65500);
         4: return $urandom_range(40, 0);
         5: return $urandom_range(32800, 32736);
         default: return $urandom_range(65536, 0);
      endcase
   endfunction

   function automatic hsl_req_type random_pixel();
      int unsigned h;
      case ($urandom_range(9))
         0, 1, 2: h = $urandom_range(65535, 0);
         // on or next to a sextant boundary, wrapped copies included
         3, 4: h = 3840 * $urandom_range(17, 0) + $urandom_range(2, 0);
         default: h = $urandom_range(23039, 0);
      endcase
      return make_pixel(h, random_level(), random_level(), $urandom_range(255, 0));
   endfunction

   task automatic send_pixel(input hsl_req_type px);
      // idle cycles carry noise on the data bus
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         req_data <= random_pixel();
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   hsl_req_type directed[$];
   int unsigned drain_cycles;

   initial begin
      directed.push_back(make_pixel(0,     65536, 32768, 0));
      directed.push_back(make_pixel(3839,  65536, 32768, 255));
      for (int k = 1; k < 6; k++)
         directed.push_back(make_pixel(3840 * k, 65536, 32768, 8'h55));
      directed.push_back(make_pixel(23039, 65536, 32768, 8'haa));
      directed.push_back(make_pixel(23040, 65536, 32768, 1));
      directed.push_back(make_pixel(65535, 65536, 32768, 128));
      directed.push_back(make_pixel(46080, 65536, 32768, 7));
      for (int k = 0; k < 6; k++)
         directed.push_back(make_pixel(1920 + 3840 * k, 40000, 20000, 16 * k));
      directed.push_back(make_pixel(5000,  0,      30000,  200));
      directed.push_back(make_pixel(5000,  131071, 131071, 255));
      directed.push_back(make_pixel(9000,  65537,  0,      0));
      directed.push_back(make_pixel(13000, 65536,  65536,  99));
      directed.push_back(make_pixel(17000, 50000,  49152,  33));
      directed.push_back(make_pixel(21000, 65536,  1,      77));
      directed.push_back(make_pixel(777,   99999,  70000,  240));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // result side has no backpressure, so only the sender idle rate varies
      sender_idle_pct = 37;
      foreach (directed[i]) send_pixel(directed[i]);
      for (int i = 0; i < 340; i++) send_pixel(random_pixel());
      sender_idle_pct = 49;
      for (int i = 0; i < 340; i++) send_pixel(random_pixel());
      sender_idle_pct = 0;
      for (int i = 0; i < 340; i++) send_pixel(random_pixel());
      start <= 1'b0;

      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < 200) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (16) @(posedge clock);
      final_check <= 1'b1;
      @(posedge clock);
      final_check <= 1'b0;
      @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
src/hslrgb_pkg.sv
src/hslrgb_front.sv
src/hslrgb_xcalc.sv
src/hslrgb_out.sv
src/hsl_to_rgb_convert_unit.sv
tb/sv/tb_hsl_to_rgb_checker.sv
tb/sv/tb_hsl_to_rgb_convert_unit.sv
